### rtl/tmb_pkg.sv
// tmb_pkg: shared constants for the task mailbox store.
// Holds field widths, stream word layout, operation codes and parameter defaults.
// No dependencies.
package tmb_pkg;

    // Field widths of the input and result words
    localparam int OP_W     = 2;
    localparam int TASK_W   = 4;
    localparam int MSG_W    = 32;
    localparam int IN_TDATA_W  = 40;   // 2 + 4 + 32 = 38, padded to whole bytes
    localparam int OUT_TDATA_W = 40;   // 1 + 1 + 32 = 34, padded to whole bytes

    // Operation codes
    localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Parameter defaults
    localparam int NUM_TASKS_DEF      = 16;
    localparam int SLOTS_PER_TASK_DEF = 4;
    localparam int DATA_WIDTH_DEF     = 32;

endpackage : tmb_pkg

### rtl/task_mailbox_slots.sv
// task_mailbox_slots: mailbox store, one group of slots per task, interleaved by task count.
// Send, clear and unused codes and a get that finds none give their result in the cycle
// after acceptance; a get that finds a message passes the payload memory read and S_READ.
// A new word waits while a get is in S_READ or the output stage holds an undrained result.
// Reset: synchronous, active low; clears all valid marks, the state and the output valid flag.
// Depends on tmb_pkg.
module task_mailbox_slots #(
    parameter int NUM_TASKS      = tmb_pkg::NUM_TASKS_DEF,
    parameter int SLOTS_PER_TASK = tmb_pkg::SLOTS_PER_TASK_DEF,
    parameter int DATA_WIDTH     = tmb_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // op [1:0], dest_task [5:2], message_data [37:6], zero [39:38]
    input  logic [tmb_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // accepted [0], found [1], read_data [33:2], zero [39:34]
    output logic [tmb_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready
);
    import tmb_pkg::*;

    localparam int DEPTH = NUM_TASKS * SLOTS_PER_TASK;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int KW    = (SLOTS_PER_TASK > 1) ? $clog2(SLOTS_PER_TASK) : 1;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                    r_state;
    logic [NUM_TASKS-1:0]      r_valid [SLOTS_PER_TASK];
    logic                      r_out_valid;
    logic                      r_out_acc;
    logic                      r_out_found;
    logic [MSG_W-1:0]          r_out_data;
    logic [DATA_WIDTH-1:0]     r_mem [DEPTH];
    logic [DATA_WIDTH-1:0]     r_mem_q;

    logic [OP_W-1:0]           w_op;
    logic [TASK_W-1:0]         w_dest;
    logic [MSG_W-1:0]          w_msg;
    logic                      w_in_fire;
    logic                      w_in_range;
    logic [TW-1:0]             w_task;
    logic [SLOTS_PER_TASK-1:0] w_slot_vld;
    logic                      w_free_hit;
    logic [KW-1:0]             w_free_slot;
    logic                      w_get_hit;
    logic [KW-1:0]             w_get_slot;
    logic                      w_send_ok;
    logic                      w_get_ok;
    logic [KW-1:0]             w_slot;
    logic [AW-1:0]             w_addr;
    logic                      w_mem_we;
    logic                      w_mem_re;
    logic                      w_any_valid;

    // Unpack the input word
    assign w_op   = i_s_axis_tdata[OP_W-1:0];
    assign w_dest = i_s_axis_tdata[OP_W+TASK_W-1:OP_W];
    assign w_msg  = i_s_axis_tdata[OP_W+TASK_W+MSG_W-1:OP_W+TASK_W];

    // Take a word when idle and the output stage is free or draining
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    assign w_in_range = (32'(w_dest) < NUM_TASKS);
    assign w_task     = TW'(w_dest);

    // Gather the task's marks and find the lowest free and lowest valid slot
    always_comb begin
        w_free_hit  = 1'b0;
        w_free_slot = '0;
        w_get_hit   = 1'b0;
        w_get_slot  = '0;
        for (int k = 0; k < SLOTS_PER_TASK; k++) begin
            w_slot_vld[k] = w_in_range && r_valid[k][w_task];
        end
        for (int k = SLOTS_PER_TASK - 1; k >= 0; k--) begin
            if (!w_slot_vld[k]) begin
                w_free_hit  = 1'b1;
                w_free_slot = KW'(k);
            end
            if (w_slot_vld[k]) begin
                w_get_hit  = 1'b1;
                w_get_slot = KW'(k);
            end
        end
    end

    assign w_send_ok = w_in_range && w_free_hit;
    assign w_get_ok  = w_in_range && w_get_hit;

    // Slot s of a task sits at s * NUM_TASKS + task
    assign w_slot   = (w_op == OP_SEND) ? w_free_slot : w_get_slot;
    assign w_addr   = AW'(32'(w_slot) * NUM_TASKS + 32'(w_task));
    assign w_mem_we = w_in_fire && (w_op == OP_SEND) && w_send_ok;
    assign w_mem_re = w_in_fire && (w_op == OP_GET) && w_get_ok;

    // Payload memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_addr] <= DATA_WIDTH'(w_msg);
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_addr];
        end
    end

    // Control, valid marks and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SLOTS_PER_TASK; k++) begin
                r_valid[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_out_acc   <= 1'b0;
                        r_out_found <= 1'b0;
                        r_out_data  <= '0;
                        case (w_op)
                            OP_SEND: begin
                                r_out_valid <= 1'b1;
                                r_out_acc   <= w_send_ok;
                                if (w_send_ok) begin
                                    r_valid[w_free_slot][w_task] <= 1'b1;
                                end
                            end
                            OP_GET: begin
                                if (w_get_ok) begin
                                    // wait in S_READ for the registered payload read
                                    r_valid[w_get_slot][w_task] <= 1'b0;
                                    r_state <= S_READ;
                                end else begin
                                    r_out_valid <= 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_out_valid <= 1'b1;
                                for (int k = 0; k < SLOTS_PER_TASK; k++) begin
                                    r_valid[k] <= '0;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_acc   <= 1'b0;
                    r_out_found <= 1'b1;
                    r_out_data  <= MSG_W'(r_mem_q);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Pack the result word
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - MSG_W - 2)'(0), r_out_data, r_out_found, r_out_acc};

    // Any mark still set, for checking
    always_comb begin
        w_any_valid = 1'b0;
        for (int k = 0; k < SLOTS_PER_TASK; k++) begin
            w_any_valid = w_any_valid || (|r_valid[k]);
        end
    end

`ifndef SYNTHESIS
    // The output stage is empty while a payload read is in flight
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("output stage busy during payload read");

    // A result never reports both a stored send and a found get
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_acc && r_out_found))
        else $error("accepted and found both set");

    // Data is zero unless a message was found
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_data == '0))
        else $error("read data set without a found message");

    // A clear leaves no mark set
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_op == OP_CLEAR)) |=> !w_any_valid)
        else $error("valid mark left after clear");
`endif

endmodule : task_mailbox_slots

### tb/tb_task_mailbox_slots.sv
// tb_task_mailbox_slots: self-checking bench for the task mailbox store, predicting every
// send, get and clear against a local copy of the slot marks and payloads.
// Depends on tmb_pkg and task_mailbox_slots.
module tb_task_mailbox_slots;
    timeunit 1ns;
    timeprecision 1ps;
    import tmb_pkg::*;

    localparam int NUM_TASKS      = NUM_TASKS_DEF;
    localparam int SLOTS_PER_TASK = SLOTS_PER_TASK_DEF;
    localparam int DEPTH          = NUM_TASKS * SLOTS_PER_TASK;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS   = 1950;
    localparam int IDLE_LIMIT     = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTS     = 20;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] dest;
        logic [MSG_W-1:0]  data;
        int                gap;     // idle cycles after this word
        bit                drain;   // hold until every result is back
    } mbx_req_t;

    // Packed from the highest bit down: read_data, found, accepted
    typedef struct packed {
        logic [MSG_W-1:0] read_data;
        logic             found;
        logic             accepted;
    } mbx_rsp_t;

    typedef struct {
        mbx_req_t req;
        mbx_rsp_t rsp;
        int       seq;
    } mbx_expect_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    task_mailbox_slots dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the store
    bit               slot_mark [DEPTH];
    logic [MSG_W-1:0] slot_word [DEPTH];

    mbx_req_t    pending_words[$];
    mbx_expect_t mailbox_results[$];
    mbx_req_t    cur_word;
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          n_sent = 0, n_full = 0, n_got = 0, n_empty = 0, n_clear = 0, n_unused = 0;
    int          idle_cycles = 0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    // Apply one word to the local store and return the result it must give
    function automatic mbx_rsp_t mailbox_apply(mbx_req_t r);
        mbx_rsp_t res;
        int       idx;
        res = '0;
        case (r.op)
            OP_SEND: begin
                if (int'(r.dest) < NUM_TASKS) begin
                    for (int k = 0; k < SLOTS_PER_TASK; k++) begin
                        idx = int'(r.dest) + NUM_TASKS * k;
                        if (idx < DEPTH && !slot_mark[idx]) begin
                            slot_mark[idx] = 1'b1;
                            slot_word[idx] = r.data;
                            res.accepted = 1'b1;
                            break;
                        end
                    end
                end
            end
            OP_GET: begin
                if (int'(r.dest) < NUM_TASKS) begin
                    for (int k = 0; k < SLOTS_PER_TASK; k++) begin
                        idx = int'(r.dest) + NUM_TASKS * k;
                        if (idx < DEPTH && slot_mark[idx]) begin
                            slot_mark[idx] = 1'b0;
                            res.read_data = slot_word[idx];
                            res.found = 1'b1;
                            break;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                for (int s = 0; s < DEPTH; s++) slot_mark[s] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MSG_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic queue_word(logic [OP_W-1:0] op, logic [TASK_W-1:0] dest,
                              logic [MSG_W-1:0] data, bit drain);
        mbx_req_t r;
        r.op    = op;
        r.dest  = dest;
        r.data  = data;
        r.gap   = pick_gap(tx_calm);
        r.drain = drain;
        pending_words.push_back(r);
    endtask

    task automatic report_mismatch(string field, int seq, logic [MSG_W-1:0] want,
                                   logic [MSG_W-1:0] got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch on word %0d: %s expected 0x%08h got 0x%08h",
                     seq, field, want, got);
    endtask

    // Driver: hold the word while stalled, then idle or launch the next one
    always @(posedge i_clk) begin
        mbx_expect_t e;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                e.req = cur_word;
                e.rsp = mailbox_apply(cur_word);
                e.seq = words_in;
                mailbox_results.push_back(e);
                words_in++;
                tx_gap = cur_word.gap;
                case (cur_word.op)
                    OP_SEND:  if (e.rsp.accepted) n_sent++; else n_full++;
                    OP_GET:   if (e.rsp.found) n_got++; else n_empty++;
                    OP_CLEAR: n_clear++;
                    default:  n_unused++;
                endcase
            end
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain && mailbox_results.size() != 0)) begin
                    cur_word = pending_words.pop_front();
                    s_tdata  <= {2'b00, cur_word.data, cur_word.dest, cur_word.op};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word against the oldest prediction
    always @(posedge i_clk) begin
        mbx_expect_t e;
        mbx_rsp_t    got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[MSG_W+1:0];
                words_out++;
                if (mailbox_results.size() == 0) begin
                    report_mismatch("unexpected result", words_out, '0, got.read_data);
                end else begin
                    e = mailbox_results.pop_front();
                    if (got.accepted !== e.rsp.accepted)
                        report_mismatch("accepted", e.seq, MSG_W'(e.rsp.accepted),
                                        MSG_W'(got.accepted));
                    if (got.found !== e.rsp.found)
                        report_mismatch("found", e.seq, MSG_W'(e.rsp.found),
                                        MSG_W'(got.found));
                    if (got.read_data !== e.rsp.read_data)
                        report_mismatch("read_data", e.seq, e.rsp.read_data, got.read_data);
                end
            end
            // switch between stall-free and stalling stretches now and then
            if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
            if (rx_stall > 0) begin
                rx_stall--;
            end else if (!rx_calm) begin
                rx_stall = pick_gap(1'b0);
            end
            m_tready <= (rx_stall == 0);
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("tb_task_mailbox_slots: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int               n;
        int               r;
        int               k;
        int               base;
        logic [TASK_W-1:0] d;

        for (int s = 0; s < DEPTH; s++) begin
            slot_mark[s] = 1'b0;
            slot_word[s] = '0;
        end

        // Directed: fill task 0 past full with extreme payloads, then drain it
        queue_word(OP_SEND, 4'd0, 32'h0000_0000, 1'b0);
        queue_word(OP_SEND, 4'd0, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_SEND, 4'd0, 32'hA5A5_5A5A, 1'b0);
        queue_word(OP_SEND, 4'd0, 32'h8000_0001, 1'b0);
        queue_word(OP_SEND, 4'd0, 32'h1234_5678, 1'b0);   // task full
        queue_word(OP_GET,  4'd15, 32'hFFFF_FFFF, 1'b0);  // empty task
        for (int i = 0; i < SLOTS_PER_TASK + 1; i++)
            queue_word(OP_GET, 4'd0, 32'h0, 1'b0);        // last one finds none
        // Lowest free slot is reused after a get
        queue_word(OP_SEND, 4'd15, 32'h0000_00FF, 1'b0);
        queue_word(OP_SEND, 4'd15, 32'hFF00_0000, 1'b0);
        queue_word(OP_GET,  4'd15, 32'h0, 1'b0);
        queue_word(OP_SEND, 4'd15, 32'h5555_AAAA, 1'b0);
        queue_word(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_GET,  4'd15, 32'h0, 1'b0);
        // Clear drops the remaining message
        queue_word(OP_CLEAR, 4'd15, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_GET,  4'd15, 32'h0, 1'b1);
        queue_word(OP_SEND, 4'd9, 32'hDEAD_BEEF, 1'b0);
        queue_word(OP_GET,  4'd9, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_GET,  4'd6, 32'h0, 1'b0);

        // Random: mostly send/get around a small window of tasks so groups fill up
        n = 0;
        base = $urandom_range(0, 15);
        while (n < RANDOM_WORDS) begin
            if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
            if ($urandom_range(0, 49) == 0) base = $urandom_range(0, 15);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                d = TASK_W'($urandom_range(0, 15));
                k = $urandom_range(3, SLOTS_PER_TASK + 2);
                for (int i = 0; i < k; i++) queue_word(OP_SEND, d, pick_word(), 1'b0);
                for (int i = 0; i < k; i++) queue_word(OP_GET, d, $urandom, 1'b0);
                n += 2 * k;
            end else if (r < 10) begin
                queue_word(OP_CLEAR, TASK_W'($urandom_range(0, 15)), $urandom, 1'b0);
                n++;
            end else if (r < 12) begin
                queue_word(OP_UNUSED, TASK_W'($urandom_range(0, 15)), $urandom, 1'b0);
                n++;
            end else begin
                if ($urandom_range(0, 3) == 0) d = TASK_W'($urandom_range(0, 15));
                else d = TASK_W'((base + $urandom_range(0, 2)) % NUM_TASKS);
                queue_word(($urandom_range(0, 99) < 55) ? OP_SEND : OP_GET, d,
                           pick_word(), (n % 700) == 350);
                n++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid || mailbox_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("words in %0d, results out %0d, mismatches %0d", words_in, words_out, errors);
        $display("sends stored %0d / refused %0d, gets hit %0d / empty %0d, clears %0d, unused %0d",
                 n_sent, n_full, n_got, n_empty, n_clear, n_unused);
        if (errors == 0 && mailbox_results.size() == 0) begin
            $display("tb_task_mailbox_slots: PASS");
        end else begin
            $display("tb_task_mailbox_slots: FAIL");
        end
        $finish;
    end

endmodule : tb_task_mailbox_slots
